/* sv/gsda_pkg.sv */
// types and constants shared by the gps sample distance accumulator
package gsda_pkg;

  localparam int SPD_W      = 16;
  localparam int SAT_W      = 6;
  localparam int ACC_W      = 16;
  localparam int RATE_W     = 6;
  localparam int CMS_W      = 13;
  localparam int CNT_W      = 32;
  localparam int SSUM_W     = 19;
  localparam int SUM_W      = 48;
  localparam int DVD_W      = SUM_W + 1;
  localparam int STEP_W     = $clog2(DVD_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  DIST_MAX = {CNT_W{1'b1}};

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP10 = RECIP_W'(52429);
  localparam int RECIP_SHIFT = 19;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SATS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 2'd2;

  localparam logic CMD_FIX   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [SAT_W-1:0]  MIN_SATS_RST = 6'd5;
  localparam logic [ACC_W-1:0]  MAX_ACC_RST  = 16'd2000;
  localparam logic [RATE_W-1:0] RATE_RST     = 6'd10;

  typedef struct packed {
    logic take_fix;
    logic take_clear;
    logic div_start;
    logic div_avg;
    logic dist_cap;
    logic avg_cap;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic close;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0] sample_number;
    logic [CMS_W-1:0] speed_cm_s;
    logic [CNT_W-1:0] session_distance_cm;
    logic [CNT_W-1:0] run_distance_cm;
    logic [CNT_W-1:0] alpha_distance_cm;
    logic             second_ready;
    logic [CMS_W-1:0] second_average_cm_s;
    logic [CNT_W-1:0] second_number;
  } res_word_t;

endpackage

/* sv/gsda_if.sv */
// channel interfaces: fix input, result output, configuration write
interface gsda_in_if import gsda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [SPD_W-1:0] ground_speed_mm_s;
  logic [SAT_W-1:0] num_satellites;
  logic [ACC_W-1:0] speed_accuracy_mm_s;

  modport source (output valid, command, ground_speed_mm_s, num_satellites,
                  speed_accuracy_mm_s, input ready);
  modport sink (input valid, command, ground_speed_mm_s, num_satellites,
                speed_accuracy_mm_s, output ready);
endinterface

interface gsda_out_if import gsda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] sample_number;
  logic [CMS_W-1:0] speed_cm_s;
  logic [CNT_W-1:0] session_distance_cm;
  logic [CNT_W-1:0] run_distance_cm;
  logic [CNT_W-1:0] alpha_distance_cm;
  logic             second_ready;
  logic [CMS_W-1:0] second_average_cm_s;
  logic [CNT_W-1:0] second_number;

  modport source (output valid, sample_number, speed_cm_s, session_distance_cm,
                  run_distance_cm, alpha_distance_cm, second_ready,
                  second_average_cm_s, second_number, input ready);
  modport sink (input valid, sample_number, speed_cm_s, session_distance_cm,
                run_distance_cm, alpha_distance_cm, second_ready,
                second_average_cm_s, second_number, output ready);
endinterface

interface gsda_cfg_if import gsda_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/gsda_div.sv */
// serial restoring divider, one quotient bit per cycle
module gsda_div import gsda_pkg::*; #(
  parameter int DIV_W = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              busy,
  output logic              done,
  output logic [DVD_W-1:0]  quotient
);

  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  dsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              done_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W:0]    diff;
  logic              ge;
  logic [DIV_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, dsr_r};
    ge      = (trial >= {1'b0, dsr_r});
    rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= steps;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - STEP_W'(1);
        done_r <= (cnt_r == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      quo_r <= '0;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* sv/gsda_ctrl.sv */
// controller state machine: sequences accept, divisions and result load
module gsda_ctrl import gsda_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  dp_stat_t  stat,
  output ctl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DSTART = 3'd1;
  localparam logic [2:0] S_DRUN   = 3'd2;
  localparam logic [2:0] S_ASTART = 3'd3;
  localparam logic [2:0] S_ARUN   = 3'd4;
  localparam logic [2:0] S_LOAD   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    accept    = in_valid && in_ready;
    cmd       = '0;
    state_nxt = state_r;
    cmd.take_fix   = accept && (in_command == CMD_FIX);
    cmd.take_clear = accept && (in_command == CMD_CLEAR);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_command == CMD_CLEAR) ? S_LOAD : S_DSTART;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DRUN;
      end
      S_DRUN: begin
        if (stat.div_done) begin
          cmd.dist_cap = 1'b1;
          state_nxt    = stat.close ? S_ASTART : S_LOAD;
        end
      end
      S_ASTART: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = 1'b1;
        state_nxt     = S_ARUN;
      end
      S_ARUN: begin
        if (stat.div_done) begin
          cmd.avg_cap = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/gsda_dp.sv */
// datapath: config registers, counters, speed sums and result register
module gsda_dp import gsda_pkg::*; #(
  parameter int MAX_RATE_HZ = 50,
  parameter int DIV_W       = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SPD_W-1:0]      ground_speed_mm_s,
  input  logic [SAT_W-1:0]      num_satellites,
  input  logic [ACC_W-1:0]      speed_accuracy_mm_s,
  input  ctl_cmd_t              cmd,
  output logic                  close,
  output logic [DVD_W-1:0]      div_dividend,
  output logic [DIV_W-1:0]      div_divisor,
  output logic [STEP_W-1:0]     div_steps,
  input  logic [DVD_W-1:0]      div_quotient,
  output res_word_t             res
);

  localparam logic [RATE_W-1:0] MAX_RATE = RATE_W'(MAX_RATE_HZ);

  logic [SAT_W-1:0]  min_sats_r;
  logic [ACC_W-1:0]  max_acc_r;
  logic [RATE_W-1:0] rate_cfg_r;

  // session, run and alpha sums always move together, so one register holds them
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  fix_r;
  logic [RATE_W-1:0] phase_r;
  logic [CNT_W-1:0]  sec_r;
  logic [SSUM_W-1:0] ssum_r;
  logic              close_r;

  logic [CMS_W-1:0]  cms_r;
  logic [SSUM_W-1:0] snap_r;
  logic [RATE_W-1:0] rate_r;
  logic [CNT_W-1:0]  dist_r;
  logic [CMS_W-1:0]  avg_r;
  res_word_t         res_r;

  logic [RATE_W-1:0]          rate_eff;
  logic [SPD_W+RECIP_W-1:0]   prod;
  logic [CMS_W-1:0]           cms;
  logic                       gate;
  logic [DVD_W-1:0]           sum_add;
  logic [SUM_W-1:0]           sum_sat;
  logic [RATE_W-1:0]          phase_inc;
  logic                       close_now;
  logic [SSUM_W-1:0]          ssum_add;
  logic [DVD_W-1:0]           half_div;

  always_comb begin
    if (rate_cfg_r == '0) begin
      rate_eff = RATE_W'(1);
    end else if (rate_cfg_r > MAX_RATE) begin
      rate_eff = MAX_RATE;
    end else begin
      rate_eff = rate_cfg_r;
    end
    prod      = ground_speed_mm_s * RECIP10;
    cms       = prod[RECIP_SHIFT+CMS_W-1:RECIP_SHIFT];
    gate      = (num_satellites >= min_sats_r) && (speed_accuracy_mm_s < max_acc_r);
    sum_add   = {1'b0, sum_r} + DVD_W'(ground_speed_mm_s);
    sum_sat   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    phase_inc = phase_r + RATE_W'(1);
    close_now = (phase_inc >= rate_eff);
    ssum_add  = ssum_r + SSUM_W'(cms);
    // round half up: (sum + 5 rate) / (10 rate)
    half_div  = DVD_W'({rate_r, 2'b00}) + DVD_W'(rate_r);
    if (cmd.div_avg) begin
      div_dividend = {snap_r, {(DVD_W-SSUM_W){1'b0}}};
      div_divisor  = DIV_W'(rate_r);
      div_steps    = STEP_W'(SSUM_W);
    end else begin
      div_dividend = {1'b0, sum_r} + half_div;
      div_divisor  = (DIV_W'(rate_r) << 3) + (DIV_W'(rate_r) << 1);
      div_steps    = STEP_W'(DVD_W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_sats_r <= MIN_SATS_RST;
      max_acc_r  <= MAX_ACC_RST;
      rate_cfg_r <= RATE_RST;
      sum_r      <= '0;
      fix_r      <= '0;
      phase_r    <= '0;
      sec_r      <= '1;
      ssum_r     <= '0;
      close_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_SATS: min_sats_r <= cfg_data[SAT_W-1:0];
          REG_MAX_ACC:  max_acc_r  <= cfg_data[ACC_W-1:0];
          REG_RATE:     rate_cfg_r <= cfg_data[RATE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take_clear) begin
        sum_r   <= '0;
        close_r <= 1'b0;
      end else if (cmd.take_fix) begin
        fix_r   <= fix_r + CNT_W'(1);
        close_r <= close_now;
        if (gate) begin
          sum_r <= sum_sat;
        end
        if (close_now) begin
          phase_r <= '0;
          ssum_r  <= '0;
          sec_r   <= sec_r + CNT_W'(1);
        end else begin
          phase_r <= phase_inc;
          ssum_r  <= ssum_add;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_clear) begin
      cms_r  <= '0;
      dist_r <= '0;
      avg_r  <= '0;
    end else if (cmd.take_fix) begin
      cms_r  <= cms;
      snap_r <= ssum_add;
      rate_r <= rate_eff;
      avg_r  <= '0;
    end
    if (cmd.dist_cap) begin
      dist_r <= (div_quotient[DVD_W-1:CNT_W] != '0) ? DIST_MAX : div_quotient[CNT_W-1:0];
    end
    if (cmd.avg_cap) begin
      avg_r <= div_quotient[CMS_W-1:0];
    end
    if (cmd.load_out) begin
      res_r.sample_number       <= fix_r;
      res_r.speed_cm_s          <= cms_r;
      res_r.session_distance_cm <= dist_r;
      res_r.run_distance_cm     <= dist_r;
      res_r.alpha_distance_cm   <= dist_r;
      res_r.second_ready        <= close_r;
      res_r.second_average_cm_s <= avg_r;
      res_r.second_number       <= close_r ? sec_r : '0;
    end
  end

  assign close = close_r;
  assign res   = res_r;

endmodule

/* sv/gps_sample_distance_accumulator_top.sv */
// top level of the gps sample distance accumulator
//
//  channel  | dir | handshake     | word
//  ---------+-----+---------------+------------------------------------------
//  cfg_ch   | in  | valid/ready   | register index, write data
//  in_ch    | in  | valid/ready   | command, speed, satellites, accuracy
//  out_ch   | out | valid/ready   | sample, speed, distances, second bucket
//
//  a fix word runs one division for the distance and, when it closes a
//  second, one more for the average, of 49 and 19 quotient bits
//  a clear word goes straight to the result load; cfg_ready is always high
//  reset is synchronous; the next word is taken while a result waits in the
//  output register, and a stalled output holds the last load until taken
module gps_sample_distance_accumulator_top import gsda_pkg::*; #(
  parameter int MAX_RATE_HZ = 50
) (
  input  logic      clk,
  input  logic      rst_n,
  gsda_cfg_if.sink  cfg_ch,
  gsda_in_if.sink   in_ch,
  gsda_out_if.source out_ch
);

  localparam int DIV_W = $clog2(10 * MAX_RATE_HZ + 1);

  ctl_cmd_t          cmd;
  dp_stat_t          stat;
  logic              close;
  logic              div_busy;
  logic              div_done;
  logic [DVD_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic [STEP_W-1:0] div_steps;
  logic [DVD_W-1:0]  div_quotient;
  res_word_t         res;

  assign cfg_ch.ready = 1'b1;
  assign stat.close    = close;
  assign stat.div_done = div_done;

  gsda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .stat       (stat),
    .cmd        (cmd)
  );

  gsda_dp #(
    .MAX_RATE_HZ (MAX_RATE_HZ),
    .DIV_W       (DIV_W)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_ch.valid),
    .cfg_index           (cfg_ch.index),
    .cfg_data            (cfg_ch.data),
    .ground_speed_mm_s   (in_ch.ground_speed_mm_s),
    .num_satellites      (in_ch.num_satellites),
    .speed_accuracy_mm_s (in_ch.speed_accuracy_mm_s),
    .cmd                 (cmd),
    .close               (close),
    .div_dividend        (div_dividend),
    .div_divisor         (div_divisor),
    .div_steps           (div_steps),
    .div_quotient        (div_quotient),
    .res                 (res)
  );

  gsda_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_ch.sample_number       = res.sample_number;
  assign out_ch.speed_cm_s          = res.speed_cm_s;
  assign out_ch.session_distance_cm = res.session_distance_cm;
  assign out_ch.run_distance_cm     = res.run_distance_cm;
  assign out_ch.alpha_distance_cm   = res.alpha_distance_cm;
  assign out_ch.second_ready        = res.second_ready;
  assign out_ch.second_average_cm_s = res.second_average_cm_s;
  assign out_ch.second_number       = res.second_number;

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_busy)
    else $error("input taken while divider busy");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.load_out))
    else $error("result valid without a load");

  a_no_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.second_ready |->
      out_ch.second_number == '0 && out_ch.second_average_cm_s == '0)
    else $error("second fields set without a closed bucket");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
